// File: src/lcvm_pkg.sv
// Package of the series cell voltage monitor: widths, reset values, register
// indexes and the sequencer state type.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package lcvm_pkg;

  localparam int CELL_TAPS = 8;
  localparam int ADDR_W    = $clog2(CELL_TAPS);
  localparam int TAP_W     = 3;
  localparam int SAMPLE_W  = 13;
  localparam int COEFF_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int GAINS_W   = 64;
  localparam int CNT_W     = 4;
  localparam int LEVEL_W   = 29;
  localparam int MV_W      = 21;
  localparam int CELL_MV_W = 22;
  localparam int CFG_IDX_W = 3;

  // Effective tap limit never exceeds eight taps.
  localparam int MAX_TAPS = (CELL_TAPS < 8) ? CELL_TAPS : 8;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET     = 29'd58982400;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX       = '1;
  localparam logic [MV_W-1:0]    MV_MAX          = '1;
  localparam logic [COEFF_W-1:0] COEFF_RESET     = 16'd64881;
  localparam logic [SAMPLE_W-1:0] THRESH_RESET   = 13'd100;
  localparam logic [CNT_W-1:0]   MAX_CELLS_RESET = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_COEFF = 3'd0,
    CFG_THRESHOLD    = 3'd1,
    CFG_MAX_CELLS    = 3'd2,
    CFG_GAINS_LOW    = 3'd3,
    CFG_GAINS_HIGH   = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULB,
    ST_LEVEL,
    ST_SCALE,
    ST_FINISH,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// File: src/lcvm_in_if.sv
// Input channel of the cell voltage monitor: one tap sample per beat.
// Depends on lcvm_pkg for the field widths.
`default_nettype none

interface lcvm_in_if;
  import lcvm_pkg::*;

  logic                valid;
  logic                ready;
  logic [TAP_W-1:0]    channel;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

`default_nettype wire

// File: src/lcvm_out_if.sv
// Result channel of the cell voltage monitor: one result per beat.
// Depends on lcvm_pkg for the field widths.
`default_nettype none

interface lcvm_out_if;
  import lcvm_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [TAP_W-1:0]            tap;
  logic signed [CELL_MV_W-1:0] cell_mv;
  logic [MV_W-1:0]             pack_mv;
  logic [CNT_W-1:0]            cells_present;
  logic                        below_threshold;
  logic                        scan_end;
  logic                        ignored;

  modport source (output valid, output tap, output cell_mv, output pack_mv,
                  output cells_present, output below_threshold, output scan_end,
                  output ignored, input ready);
  modport sink   (input valid, input tap, input cell_mv, input pack_mv,
                  input cells_present, input below_threshold, input scan_end,
                  input ignored, output ready);
endinterface

`default_nettype wire

// File: src/lipo_cell_voltage_monitor_top.sv
// Series cell voltage monitor: per-tap smoothing memory, scaling and scan control.
// Depends on lcvm_pkg, lcvm_in_if and lcvm_out_if.
//
// Usage: samples arrive on in_bus one tap per beat, channel 0 first. Each beat
// yields exactly one result beat on out_bus carrying the tap's cell voltage,
// the pack total so far, the cell count and the scan flags.
// A sample that is not skipped and passes the presence test takes these steps
// from acceptance to the result register: the memory read with the sample
// product, the old-level product, the level update with write-back, the gain
// product and the final difference. The smoothing memory has a single shared
// read-modify-write. A skipped sample or a missing cell goes straight to the
// output step. One sample is in work at a time; the next is taken at the
// earliest in the cycle after the output register loads.
// The result sits in an output register, so a new sample is accepted while a
// result waits; a stalled receiver only holds the sequencer at the final
// step once a second result is ready.
// Reset (rst_n low, synchronous) restores the register defaults and marks all
// smoothing entries as holding the start level of 900 counts; no clearing pass.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while idle; user's duty, not enforced.
`default_nettype none

module lipo_cell_voltage_monitor_top (
  input  wire                           clk,
  input  wire                           rst_n,
  lcvm_in_if.sink                       in_bus,
  lcvm_out_if.source                    out_bus,
  input  wire                           cfg_we,
  input  wire [lcvm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [lcvm_pkg::GAINS_W-1:0]   cfg_wdata
);
  import lcvm_pkg::*;

  // Configuration registers.
  logic [COEFF_W-1:0]  coeff_r;
  logic [SAMPLE_W-1:0] thresh_r;
  logic [CNT_W-1:0]    max_cells_r;
  logic [GAINS_W-1:0]  gain_lo_r;
  logic [GAINS_W-1:0]  gain_hi_r;

  // Scan state.
  state_t                state_r, state_nxt;
  logic                  scan_stopped_r;
  logic [MV_W-1:0]       prev_mv_r;
  logic [MV_W-1:0]       pack_r;
  logic [CNT_W-1:0]      present_r;
  logic [CELL_TAPS-1:0]  lvl_valid_r;
  logic [LEVEL_W-1:0]    lvl_mem [CELL_TAPS];

  // Datapath registers.
  logic [TAP_W-1:0]            ch_r;
  logic [29:0]                 p_a_r;
  logic [44:0]                 p_b_r;
  logic [LEVEL_W-1:0]          rd_data_r;
  logic                        rd_valid_r;
  logic [LEVEL_W-1:0]          nl_r;
  logic [29:0]                 prod_r;
  logic signed [CELL_MV_W-1:0] res_cell_r;
  logic                        res_below_r;
  logic                        res_end_r;
  logic                        res_ign_r;

  // Output register.
  logic                        out_valid_r;
  logic [TAP_W-1:0]            out_tap_r;
  logic signed [CELL_MV_W-1:0] out_cell_r;
  logic [MV_W-1:0]             out_pack_r;
  logic [CNT_W-1:0]            out_present_r;
  logic                        out_below_r;
  logic                        out_end_r;
  logic                        out_ign_r;

  logic                 accept;
  logic                 first_tap;
  logic                 stopped_eff;
  logic [MV_W-1:0]      prev_eff;
  logic [CNT_W-1:0]     lim;
  logic                 skip;
  logic                 missing;
  logic                 out_load;
  logic [LEVEL_W-1:0]   old_level;
  logic [46:0]          acc;
  logic [30:0]          nl_full;
  logic [LEVEL_W-1:0]   nl_sat;
  logic [29:0]          level_rnd;
  logic [13:0]          level;
  logic [2*GAINS_W-1:0] gains_all;
  logic [GAIN_W-1:0]    gain;
  logic [30:0]          mv_rnd;
  logic [22:0]          mv_full;
  logic [MV_W-1:0]      mv;
  logic signed [CELL_MV_W-1:0] cell_diff;
  logic                 last_tap;

  always_comb begin
    lim = (max_cells_r > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : max_cells_r;
    first_tap   = (in_bus.channel == '0);
    stopped_eff = first_tap ? 1'b0 : scan_stopped_r;
    prev_eff    = first_tap ? '0 : prev_mv_r;
    skip        = stopped_eff || ({1'b0, in_bus.channel} >= lim);
    missing     = (in_bus.sample < thresh_r);
    accept      = in_bus.valid && in_bus.ready;
    out_load    = (state_r == ST_OUT) && (!out_valid_r || out_bus.ready);

    old_level = rd_valid_r ? rd_data_r : LEVEL_RESET;

    // Filter update: old products combined, rounded half up, saturated.
    acc     = 47'({p_a_r, 16'b0}) + 47'(p_b_r) + 47'd32768;
    nl_full = acc[46:16];
    nl_sat  = (|nl_full[30:29]) ? LEVEL_MAX : nl_full[LEVEL_W-1:0];

    level_rnd = 30'(nl_r) + 30'd32768;
    level     = level_rnd[29:16];
    gains_all = {gain_hi_r, gain_lo_r};
    gain      = gains_all[{ch_r, 4'b0} +: GAIN_W];

    mv_rnd    = 31'(prod_r) + 31'd128;
    mv_full   = mv_rnd[30:8];
    mv        = (|mv_full[22:21]) ? MV_MAX : mv_full[MV_W-1:0];
    // Both operands are non-negative and below 2^21, so no saturation is needed.
    cell_diff = $signed({1'b0, mv}) - $signed({1'b0, prev_mv_r});
    last_tap  = ((CNT_W'(ch_r) + CNT_W'(1)) == lim);
  end

  assign in_bus.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (skip || missing) ? ST_OUT : ST_MULB;
        end
      end
      ST_MULB:   state_nxt = ST_LEVEL;
      ST_LEVEL:  state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Configuration and scan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r        <= COEFF_RESET;
      thresh_r       <= THRESH_RESET;
      max_cells_r    <= MAX_CELLS_RESET;
      gain_lo_r      <= '0;
      gain_hi_r      <= '0;
      scan_stopped_r <= 1'b0;
      prev_mv_r      <= '0;
      pack_r         <= '0;
      present_r      <= (MAX_CELLS_RESET > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                             : MAX_CELLS_RESET;
      lvl_valid_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FILTER_COEFF: coeff_r     <= cfg_wdata[COEFF_W-1:0];
          CFG_THRESHOLD:    thresh_r    <= cfg_wdata[SAMPLE_W-1:0];
          CFG_MAX_CELLS:    max_cells_r <= cfg_wdata[CNT_W-1:0];
          CFG_GAINS_LOW:    gain_lo_r   <= cfg_wdata;
          CFG_GAINS_HIGH:   gain_hi_r   <= cfg_wdata;
          default: ;
        endcase
      end

      if (accept) begin
        if (first_tap) begin
          prev_mv_r <= '0;
        end
        if (!skip && missing) begin
          present_r      <= CNT_W'(in_bus.channel);
          pack_r         <= prev_eff;
          scan_stopped_r <= 1'b1;
        end else if (first_tap) begin
          scan_stopped_r <= 1'b0;
        end
      end

      if (state_r == ST_LEVEL) begin
        lvl_valid_r[ch_r[ADDR_W-1:0]] <= 1'b1;
      end

      if (state_r == ST_FINISH) begin
        prev_mv_r <= mv;
        pack_r    <= mv;
        present_r <= lim;
        if (last_tap) begin
          scan_stopped_r <= 1'b1;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Smoothing memory: read at acceptance, written back after the update.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= lvl_mem[in_bus.channel[ADDR_W-1:0]];
    end
    if (state_r == ST_LEVEL) begin
      lvl_mem[ch_r[ADDR_W-1:0]] <= nl_sat;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r        <= in_bus.channel;
      rd_valid_r  <= lvl_valid_r[in_bus.channel[ADDR_W-1:0]];
      p_a_r       <= 30'(in_bus.sample) * 30'(17'h10000 - {1'b0, coeff_r});
      res_cell_r  <= '0;
      res_below_r <= !skip && missing;
      res_end_r   <= !skip && missing;
      res_ign_r   <= skip;
    end
    if (state_r == ST_MULB) begin
      p_b_r <= 45'(old_level) * 45'(coeff_r);
    end
    if (state_r == ST_LEVEL) begin
      nl_r <= nl_sat;
    end
    if (state_r == ST_SCALE) begin
      prod_r <= 30'(level) * 30'(gain);
    end
    if (state_r == ST_FINISH) begin
      res_cell_r <= cell_diff;
      res_end_r  <= last_tap;
    end
    if (out_load) begin
      out_tap_r     <= ch_r;
      out_cell_r    <= res_cell_r;
      out_pack_r    <= pack_r;
      out_present_r <= present_r;
      out_below_r   <= res_below_r;
      out_end_r     <= res_end_r;
      out_ign_r     <= res_ign_r;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.tap             = out_tap_r;
  assign out_bus.cell_mv         = out_cell_r;
  assign out_bus.pack_mv         = out_pack_r;
  assign out_bus.cells_present   = out_present_r;
  assign out_bus.below_threshold = out_below_r;
  assign out_bus.scan_end        = out_end_r;
  assign out_bus.ignored         = out_ign_r;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench of the series cell voltage monitor: drives tap samples and register
// writes, predicts every result beat in a scoreboard class and compares it field by field.
// Depends on lcvm_pkg, lcvm_in_if, lcvm_out_if and lipo_cell_voltage_monitor_top.
`default_nettype none

package cell_scan_tb_pkg;
  import lcvm_pkg::*;

  typedef struct {
    logic [TAP_W-1:0]            tap;
    logic signed [CELL_MV_W-1:0] cell_mv;
    logic [MV_W-1:0]             pack_mv;
    logic [CNT_W-1:0]            cells_present;
    logic                        below_threshold;
    logic                        scan_end;
    logic                        ignored;
  } tap_reading_t;

  class cell_scan_scoreboard;
    logic [COEFF_W-1:0]  coeff_q16;
    logic [SAMPLE_W-1:0] threshold;
    logic [CNT_W-1:0]    max_cells_reg;
    logic [GAINS_W-1:0]  gains_low;
    logic [GAINS_W-1:0]  gains_high;
    logic [LEVEL_W-1:0]  level_q16 [CELL_TAPS];
    longint              prev_tap_mv;
    longint              pack_total;
    logic [CNT_W-1:0]    present;
    bit                  scan_halted;
    tap_reading_t        expected_readings [$];
    int                  errors;

    function new();
      coeff_q16     = COEFF_RESET;
      threshold     = THRESH_RESET;
      max_cells_reg = MAX_CELLS_RESET;
      gains_low     = '0;
      gains_high    = '0;
      foreach (level_q16[i]) level_q16[i] = LEVEL_RESET;
      prev_tap_mv   = 0;
      pack_total    = 0;
      present       = (MAX_CELLS_RESET > MAX_TAPS) ? CNT_W'(MAX_TAPS) : MAX_CELLS_RESET;
      scan_halted   = 1'b0;
      errors        = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [GAINS_W-1:0] value);
      case (idx)
        CFG_FILTER_COEFF: coeff_q16     = value[COEFF_W-1:0];
        CFG_THRESHOLD:    threshold     = value[SAMPLE_W-1:0];
        CFG_MAX_CELLS:    max_cells_reg = value[CNT_W-1:0];
        CFG_GAINS_LOW:    gains_low     = value;
        CFG_GAINS_HIGH:   gains_high    = value;
        default: ;
      endcase
    endfunction

    // Works out the reading that an accepted sample must produce.
    function void note_sample(logic [TAP_W-1:0] channel, logic [SAMPLE_W-1:0] sample);
      tap_reading_t r;
      int           idx;
      int           lim;
      logic [63:0]  weight;
      logic [63:0]  acc;
      logic [63:0]  new_level;
      logic [63:0]  counts;
      logic [63:0]  tap_mv;
      logic [15:0]  gain;
      longint       diff;
      idx = channel;
      if (idx == 0) begin
        scan_halted = 1'b0;
        prev_tap_mv = 0;
      end
      lim = (max_cells_reg > MAX_TAPS) ? MAX_TAPS : max_cells_reg;
      diff = 0;
      r.below_threshold = 1'b0;
      r.scan_end = 1'b0;
      r.ignored = 1'b0;
      if (scan_halted || idx >= lim) begin
        r.ignored = 1'b1;
      end else if (sample < threshold) begin
        present     = CNT_W'(idx);
        pack_total  = (idx == 0) ? 0 : prev_tap_mv;
        scan_halted = 1'b1;
        r.below_threshold = 1'b1;
        r.scan_end = 1'b1;
      end else begin
        weight    = 64'(coeff_q16);
        acc       = (64'(sample) << 16) * (64'd65536 - weight) + 64'(level_q16[idx]) * weight;
        new_level = (acc + 64'd32768) >> 16;
        if (new_level > 64'(LEVEL_MAX)) new_level = 64'(LEVEL_MAX);
        level_q16[idx] = new_level[LEVEL_W-1:0];
        counts = (new_level + 64'd32768) >> 16;
        gain   = (idx < 4) ? gains_low[16*idx +: 16] : gains_high[16*(idx-4) +: 16];
        tap_mv = (counts * 64'(gain) + 64'd128) >> 8;
        if (tap_mv > 64'(MV_MAX)) tap_mv = 64'(MV_MAX);
        diff = longint'(tap_mv) - prev_tap_mv;
        if (diff > 2097151) diff = 2097151;
        if (diff < -2097152) diff = -2097152;
        prev_tap_mv = longint'(tap_mv);
        pack_total  = longint'(tap_mv);
        present     = CNT_W'(lim);
        if (idx + 1 == lim) begin
          scan_halted = 1'b1;
          r.scan_end = 1'b1;
        end
      end
      r.tap           = channel;
      r.cell_mv       = diff[CELL_MV_W-1:0];
      r.pack_mv       = pack_total[MV_W-1:0];
      r.cells_present = present;
      expected_readings.push_back(r);
    endfunction

    function void check_reading(tap_reading_t got);
      tap_reading_t want;
      if (expected_readings.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat on tap %0d", got.tap);
        return;
      end
      want = expected_readings.pop_front();
      if (got.tap !== want.tap || got.cell_mv !== want.cell_mv ||
          got.pack_mv !== want.pack_mv || got.cells_present !== want.cells_present ||
          got.below_threshold !== want.below_threshold ||
          got.scan_end !== want.scan_end || got.ignored !== want.ignored) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected tap %0d cell %0d pack %0d cells %0d below %0b end %0b ign %0b",
                   want.tap, want.cell_mv, want.pack_mv, want.cells_present,
                   want.below_threshold, want.scan_end, want.ignored);
          $display("          actual   tap %0d cell %0d pack %0d cells %0d below %0b end %0b ign %0b",
                   got.tap, got.cell_mv, got.pack_mv, got.cells_present,
                   got.below_threshold, got.scan_end, got.ignored);
        end
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass
endpackage

module testbench;
  import lcvm_pkg::*;
  import cell_scan_tb_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  cfg_index_t         cfg_index;
  logic [GAINS_W-1:0] cfg_wdata;

  lcvm_in_if  in_bus ();
  lcvm_out_if out_bus ();

  lipo_cell_voltage_monitor_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cell_scan_scoreboard sb = new();

  bit steady;
  int sent;
  int cur_lim;
  int cur_thresh;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL lipo_cell_voltage_monitor_top");
    $finish;
  end

  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < 31);
  endfunction

  // Result side: check each accepted beat, then decide whether to stall.
  initial begin
    tap_reading_t got;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got.tap             = out_bus.tap;
        got.cell_mv         = out_bus.cell_mv;
        got.pack_mv         = out_bus.pack_mv;
        got.cells_present   = out_bus.cells_present;
        got.below_threshold = out_bus.below_threshold;
        got.scan_end        = out_bus.scan_end;
        got.ignored         = out_bus.ignored;
        sb.check_reading(got);
      end
      out_bus.ready <= !idle_roll();
    end
  end

  task automatic send_sample(input int ch, input int s);
    while (idle_roll()) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.channel <= ch[TAP_W-1:0];
    in_bus.sample  <= s[SAMPLE_W-1:0];
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    sb.note_sample(ch[TAP_W-1:0], s[SAMPLE_W-1:0]);
    sent++;
  endtask

  // Holds the sender off until every outstanding result beat has arrived.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [GAINS_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] coeff, input logic [12:0] thresh,
                            input logic [3:0] maxc, input logic [63:0] lo,
                            input logic [63:0] hi);
    write_reg(CFG_FILTER_COEFF, 64'(coeff));
    write_reg(CFG_THRESHOLD, 64'(thresh));
    write_reg(CFG_MAX_CELLS, 64'(maxc));
    write_reg(CFG_GAINS_LOW, lo);
    write_reg(CFG_GAINS_HIGH, hi);
    cfg_we <= 1'b0;
    cur_lim    = (maxc > MAX_TAPS) ? MAX_TAPS : maxc;
    cur_thresh = thresh;
  endtask

  function automatic logic [63:0] random_gains();
    logic [63:0] g;
    case ($urandom_range(3))
      0: g = '1;
      1: begin
        for (int k = 0; k < 4; k++) g[16*k +: 16] = 16'($urandom_range(1024));
      end
      default: g = {$urandom, $urandom};
    endcase
    return g;
  endfunction

  // Mostly present cells; now and then one that reads below the threshold.
  function automatic int pick_sample();
    if (cur_thresh > 0 && $urandom_range(99) < 6) return $urandom_range(cur_thresh - 1);
    return $urandom_range(8191, cur_thresh);
  endfunction

  task automatic random_config();
    logic [15:0] coeff;
    logic [12:0] thresh;
    logic [3:0]  maxc;
    case ($urandom_range(3))
      0: coeff = 16'd0;
      1: coeff = 16'hFFFF;
      2: coeff = COEFF_RESET;
      default: coeff = 16'($urandom_range(65535));
    endcase
    case ($urandom_range(5))
      0: thresh = 13'd0;
      1: thresh = 13'h1FFF;
      2, 3: thresh = 13'($urandom_range(300));
      4: thresh = THRESH_RESET;
      default: thresh = 13'($urandom_range(8191));
    endcase
    if ($urandom_range(9) == 0) maxc = 4'($urandom_range(15, 9));
    else maxc = 4'($urandom_range(8, 1));
    set_config(coeff, thresh, maxc, random_gains(), random_gains());
  endtask

  initial begin
    int phase;
    int mark;
    int directed_count;
    int kind;
    int n;
    in_bus.valid   <= 1'b0;
    in_bus.channel <= '0;
    in_bus.sample  <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_FILTER_COEFF;
    cfg_wdata      <= '0;
    rst_n          <= 1'b0;
    steady  = 1'b0;
    sent    = 0;
    cur_lim = MAX_TAPS;
    cur_thresh = THRESH_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults: zero gains, so the smoothed levels move but read 0 mV.
    send_sample(0, 4000);
    send_sample(1, 4100);
    drain();

    // No smoothing, full gains on the low taps and unity on the high taps,
    // so the fifth cell swings hard negative.
    set_config(16'd0, 13'd100, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0100_0100_0100_0100);
    for (int ch = 0; ch < 8; ch++) send_sample(ch, (ch < 4) ? 8191 : 8191 - 1000 * ch);
    send_sample(0, 0);      // missing cell right at the bottom tap
    send_sample(1, 5000);   // scan already stopped
    send_sample(0, 6000);
    send_sample(1, 99);     // missing cell in mid-scan
    send_sample(2, 7000);
    send_sample(0, 7000);
    send_sample(2, 7000);   // out of order, then repeated
    send_sample(2, 7000);
    send_sample(1, 100);    // exactly at the threshold counts as present
    drain();

    // Heaviest smoothing, zero threshold, three taps wired.
    set_config(16'hFFFF, 13'd0, 4'd3, {$urandom, $urandom}, 64'h0);
    send_sample(0, 0);
    send_sample(1, 8191);
    send_sample(2, 123);    // last wired tap ends the scan
    send_sample(0, 2222);
    send_sample(5, 3333);   // beyond the wired taps
    drain();

    // No taps wired at all: everything is skipped.
    set_config(16'd1, 13'h1FFF, 4'd0, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321);
    send_sample(0, 8191);
    send_sample(3, 4096);
    drain();

    // Oversized register value clamps to eight taps.
    set_config(COEFF_RESET, 13'h1FFF, 4'd15, random_gains(), random_gains());
    send_sample(0, 8190);
    send_sample(0, 8191);
    send_sample(7, 8191);
    drain();
    directed_count = sent;

    phase = 0;
    while (sent - directed_count < 450) begin
      random_config();
      steady = (phase == 3);
      mark = sent;
      while (sent - mark < 50) begin
        kind = $urandom_range(99);
        if (kind < 75 && cur_lim > 0) begin
          for (int ch = 0; ch < cur_lim; ch++) send_sample(ch, pick_sample());
        end else if (kind < 90) begin
          n = $urandom_range(6, 1);
          repeat (n) send_sample($urandom_range(7), $urandom_range(8191));
        end else begin
          send_sample($urandom_range(7), pick_sample());
        end
      end
      drain();
      phase++;
    end
    steady = 1'b0;

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS lipo_cell_voltage_monitor_top");
    end else begin
      $display("FAIL lipo_cell_voltage_monitor_top");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: filelist.f
src/lcvm_pkg.sv
src/lcvm_in_if.sv
src/lcvm_out_if.sv
src/lipo_cell_voltage_monitor_top.sv
sim/testbench.sv
